// ===== rtl/shared_buffer_multi_queue_top_defines.svh =====
// assertion macros used by the checker file
`ifndef SHARED_BUFFER_MULTI_QUEUE_TOP_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SBMQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbmq assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SBMQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbmq assertion failed");

`endif

// ===== rtl/sbmq_pkg.sv =====
package sbmq_pkg;

    // sizes of the queue table and the slot store
    localparam int NUM_QUEUES = 8;
    localparam int NUM_SLOTS  = 256;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // item field widths
    localparam int QID_W      = 3;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int IN_USER_W  = QID_W + 1;

    // item kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // slot link with a null flag on top
    typedef struct packed {
        logic              nil;
        logic [SLOT_W-1:0] idx;
    } link_t;

    localparam link_t LINK_NIL = '{nil: 1'b1, idx: '0};

    // controller to datapath
    typedef struct packed {
        logic issue;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/shared_buffer_multi_queue_top.sv =====
// channel | dir | tdata            | tuser
// s_*     | in  | value[31:0]      | kind[0], queue_id[3:1]
// m_*     | out | data[31:0]       | status[1:0]
//
// each word goes through accept with the link store read, then the
// dependent link write and queue update; one word is in flight at a time
// a result waiting in the output register does not hold off the next accept;
// it holds the update step only while m_tready stays low
// rst_n clears queues to empty and the free list to all slots at once
module shared_buffer_multi_queue_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sbmq_pkg::WORD_W-1:0]      s_tdata,  // value
    input  logic [sbmq_pkg::IN_USER_W-1:0]   s_tuser,  // kind, queue_id
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sbmq_pkg::WORD_W-1:0]      m_tdata,  // data
    output logic [sbmq_pkg::STATUS_W-1:0]    m_tuser   // status
);

    import sbmq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    sbmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // queue table, slot stores and output register
    sbmq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/sbmq_ram.sv =====
module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sbmq_ctrl.sv =====
module sbmq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output sbmq_pkg::cmd_t cmd,
    input  sbmq_pkg::sts_t sts
);

    import sbmq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // commands: issue on accept, commit once the output register is free
    always_comb
    begin
        s_tready   = (state_reg == S_IDLE);
        cmd.issue  = s_tvalid && s_tready;
        cmd.commit = (state_reg == S_EXEC) && sts.out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.issue)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sbmq_dp.sv =====
module sbmq_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbmq_pkg::cmd_t                    cmd,
    output sbmq_pkg::sts_t                    sts,
    input  logic [sbmq_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic [sbmq_pkg::WORD_W-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbmq_pkg::STATUS_W-1:0]     m_tuser,
    output logic [sbmq_pkg::WORD_W-1:0]       m_tdata
);

    import sbmq_pkg::*;

    // reset contents of a link entry: next slot, last one null
    function automatic link_t link_reset(input logic [SLOT_W-1:0] a);
        link_t r;
        r.nil = (a == SLOT_W'(NUM_SLOTS - 1));
        r.idx = a + SLOT_W'(1);
        return r;
    endfunction

    // queue table and free list head
    link_t head_reg [NUM_QUEUES];
    link_t tail_reg [NUM_QUEUES];
    link_t free_head_reg;
    link_t free_head_next;

    // link entries written since reset
    logic [NUM_SLOTS-1:0] lnk_vld_reg;

    // item in flight
    logic              op_kind_reg;
    logic              op_ok_reg;
    logic              op_hd_nil_reg;
    logic [QIDX_W-1:0] op_q_reg;
    logic [SLOT_W-1:0] op_idx_reg;
    logic              rd_vld_reg;

    // output register
    logic                out_vld_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [WORD_W-1:0]   out_data_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic [WORD_W-1:0]   out_data_next;

    // incoming word decode
    logic              in_kind;
    logic [QID_W-1:0]  in_qid;
    logic [QIDX_W-1:0] in_q;
    logic              in_q_ok;
    link_t             hd;
    link_t             tl;
    logic              enq_ok;
    logic              deq_ok;
    logic              in_ok;
    logic [SLOT_W-1:0] iss_idx;

    // memory ports
    logic              lw_en;
    logic [SLOT_W-1:0] lw_addr;
    link_t             lw_data;
    logic [LINK_W-1:0] lr_q;
    link_t             link_rd;
    logic              dw_en;
    logic              dr_en;
    logic [WORD_W-1:0] dr_q;

    // decode the accepted word
    always_comb
    begin
        in_kind = s_tuser[0];
        in_qid  = s_tuser[QID_W:1];
        in_q    = QIDX_W'(in_qid);
        in_q_ok = int'(in_qid) < NUM_QUEUES;
        hd      = head_reg[in_q];
        tl      = tail_reg[in_q];
        enq_ok  = in_q_ok && !free_head_reg.nil;
        deq_ok  = in_q_ok && !hd.nil;
        in_ok   = (in_kind == KIND_ENQ) ? enq_ok : deq_ok;
        iss_idx = (in_kind == KIND_ENQ) ? free_head_reg.idx : hd.idx;
    end

    // link store write: tail link on issue, own link on commit
    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = tl.idx;
        lw_data = '{nil: 1'b0, idx: free_head_reg.idx};
        if (cmd.issue && (in_kind == KIND_ENQ) && enq_ok && !hd.nil && !tl.nil)
        begin
            lw_en = 1'b1;
        end
        else if (cmd.commit && op_ok_reg)
        begin
            lw_en   = 1'b1;
            lw_addr = op_idx_reg;
            lw_data = (op_kind_reg == KIND_ENQ) ? LINK_NIL : free_head_reg;
        end
    end

    assign dw_en = cmd.issue && (in_kind == KIND_ENQ) && enq_ok;
    assign dr_en = cmd.issue && (in_kind == KIND_DEQ) && deq_ok;

    sbmq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (lw_en),
        .waddr (lw_addr),
        .wdata (lw_data),
        .re    (cmd.issue && in_ok),
        .raddr (iss_idx),
        .rdata (lr_q)
    );

    sbmq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (dw_en),
        .waddr (free_head_reg.idx),
        .wdata (s_tdata),
        .re    (dr_en),
        .raddr (hd.idx),
        .rdata (dr_q)
    );

    // unwritten link entries read as their reset contents
    assign link_rd = rd_vld_reg ? link_t'(lr_q) : link_reset(op_idx_reg);

    // free list head and result
    always_comb
    begin
        free_head_next  = free_head_reg;
        out_status_next = ST_DONE;
        out_data_next   = '0;
        if (op_kind_reg == KIND_ENQ)
        begin
            if (op_ok_reg)
            begin
                free_head_next = link_rd;
            end
            else
            begin
                out_status_next = ST_FULL;
            end
        end
        else
        begin
            if (op_ok_reg)
            begin
                free_head_next = '{nil: 1'b0, idx: op_idx_reg};
                out_data_next  = dr_q;
            end
            else
            begin
                out_status_next = ST_EMPTY;
                out_data_next   = '1;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            op_kind_reg   <= in_kind;
            op_ok_reg     <= in_ok;
            op_hd_nil_reg <= hd.nil;
            op_q_reg      <= in_q;
            op_idx_reg    <= iss_idx;
            rd_vld_reg    <= lnk_vld_reg[iss_idx];
        end
        if (cmd.commit)
        begin
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
        end
    end

    // queue table, free head, link valid bits, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= LINK_NIL;
                tail_reg[i] <= LINK_NIL;
            end
            free_head_reg <= '{nil: 1'b0, idx: '0};
            lnk_vld_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (lw_en)
            begin
                lnk_vld_reg[lw_addr] <= 1'b1;
            end
            if (cmd.commit)
            begin
                free_head_reg <= free_head_next;
                if (op_ok_reg)
                begin
                    if (op_kind_reg == KIND_ENQ)
                    begin
                        if (op_hd_nil_reg)
                        begin
                            head_reg[op_q_reg] <= '{nil: 1'b0, idx: op_idx_reg};
                        end
                        tail_reg[op_q_reg] <= '{nil: 1'b0, idx: op_idx_reg};
                    end
                    else
                    begin
                        head_reg[op_q_reg] <= link_rd;
                    end
                end
            end
            if (cmd.commit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free = !out_vld_reg || m_tready;
    assign m_tvalid     = out_vld_reg;
    assign m_tuser      = out_status_reg;
    assign m_tdata      = out_data_reg;

endmodule

// ===== rtl/sbmq_checker.sv =====
`include "shared_buffer_multi_queue_top_defines.svh"

module sbmq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sbmq_pkg::WORD_W-1:0]      m_tdata,
    input logic [sbmq_pkg::STATUS_W-1:0]    m_tuser
);

    import sbmq_pkg::*;

    // a stalled result word holds
    `SBMQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    // one word in flight: no accept right after an accept
    `SBMQ_ASSERT_NEXT(a_one_inflight, s_tvalid && s_tready, !s_tready)

    // full store answers with a zero word
    `SBMQ_ASSERT_NOW(a_full_zero, m_tvalid && (m_tuser == ST_FULL), m_tdata == '0)

    // empty queue answers with all ones
    `SBMQ_ASSERT_NOW(a_empty_ones, m_tvalid && (m_tuser == ST_EMPTY), m_tdata == '1)

endmodule

bind shared_buffer_multi_queue_top sbmq_checker u_sbmq_checker (.*);

// ===== bench/tb_shared_buffer_multi_queue_top.sv =====
module tb_shared_buffer_multi_queue_top;
    import sbmq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RCV_HOLD_CYCLES = 60;
    localparam int NUM_DIR = 18;

    // one result word as seen on the m_* channel
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data;
    } result_t;

    // one directed row, with the result typed in where it is obvious
    typedef struct packed {
        logic                kind;
        logic [QID_W-1:0]    qid;
        logic [WORD_W-1:0]   value;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data;
    } step_t;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    const step_t dir_steps [NUM_DIR] = '{
        '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b1, ST_EMPTY, ALL_ONES},
        '{KIND_DEQ, 3'd7, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, ALL_ONES},
        '{KIND_ENQ, 3'd0, 32'h7FFF_FFFF, 1'b1, ST_DONE, 32'h0},
        '{KIND_ENQ, 3'd0, 32'h8000_0000, 1'b1, ST_DONE, 32'h0},
        '{KIND_ENQ, 3'd7, 32'hFFFF_FFFF, 1'b1, ST_DONE, 32'h0},
        '{KIND_ENQ, 3'd7, 32'h0000_0000, 1'b1, ST_DONE, 32'h0},
        '{KIND_ENQ, 3'd3, 32'hA5A5_A5A5, 1'b1, ST_DONE, 32'h0},
        '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b1, ST_DONE, 32'h7FFF_FFFF},
        '{KIND_DEQ, 3'd0, 32'hFFFF_FFFF, 1'b1, ST_DONE, 32'h8000_0000},
        // queue 0 now empty with its tail left behind
        '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b1, ST_EMPTY, ALL_ONES},
        '{KIND_ENQ, 3'd0, 32'h5A5A_5A5A, 1'b1, ST_DONE, 32'h0},
        '{KIND_ENQ, 3'd0, 32'h0000_0001, 1'b1, ST_DONE, 32'h0},
        '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b1, ST_DONE, 32'h5A5A_5A5A},
        '{KIND_DEQ, 3'd7, 32'h0000_0000, 1'b1, ST_DONE, 32'hFFFF_FFFF},
        '{KIND_DEQ, 3'd3, 32'h0000_0000, 1'b1, ST_DONE, 32'hA5A5_A5A5},
        '{KIND_DEQ, 3'd7, 32'h0000_0000, 1'b1, ST_DONE, 32'h0000_0000},
        '{KIND_DEQ, 3'd0, 32'h0000_0000, 1'b1, ST_DONE, 32'h0000_0001},
        '{KIND_DEQ, 3'd3, 32'h0000_0000, 1'b1, ST_EMPTY, ALL_ONES}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata;
    logic [IN_USER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [WORD_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // side band that travels with the offered word
    logic                tag_typed;
    logic [STATUS_W-1:0] tag_status;
    logic [WORD_W-1:0]   tag_data;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int rcv_hold_left = 0;
    int fail_count = 0;

    // predicted queue table, slot store and free list
    link_t             pq_head [NUM_QUEUES];
    link_t             pq_tail [NUM_QUEUES];
    link_t             slot_next [NUM_SLOTS];
    logic [WORD_W-1:0] slot_word [NUM_SLOTS];
    link_t             free_top;
    int                slots_taken;

    result_t due_results [$];

    shared_buffer_multi_queue_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // empty queues, every slot on the free list
    task automatic clear_queue_state();
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            pq_head[q] = LINK_NIL;
            pq_tail[q] = LINK_NIL;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_next[i] = (i + 1 < NUM_SLOTS) ? link_t'{nil: 1'b0, idx: SLOT_W'(i + 1)}
                                               : LINK_NIL;
            slot_word[i] = '0;
        end
        free_top = link_t'{nil: 1'b0, idx: '0};
        slots_taken = 0;
    endtask

    // apply one enqueue or dequeue to the predicted store
    function automatic result_t apply_queue_op(input logic kind, input logic [QID_W-1:0] qid,
                                               input logic [WORD_W-1:0] value);
        result_t r;
        link_t   slot;
        if (kind == KIND_ENQ)
        begin
            r.data = '0;
            if (int'(qid) >= NUM_QUEUES || free_top.nil)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                slot = free_top;
                free_top = slot_next[slot.idx];
                if (pq_head[qid].nil)
                    pq_head[qid] = slot;
                else if (!pq_tail[qid].nil)
                    slot_next[pq_tail[qid].idx] = slot;
                slot_next[slot.idx] = LINK_NIL;
                pq_tail[qid] = slot;
                slot_word[slot.idx] = value;
                slots_taken++;
                r.status = ST_DONE;
            end
        end
        else
        begin
            if (int'(qid) >= NUM_QUEUES || pq_head[qid].nil)
            begin
                r.status = ST_EMPTY;
                r.data = ALL_ONES;
            end
            else
            begin
                // tail is left stale when the queue runs dry
                slot = pq_head[qid];
                pq_head[qid] = slot_next[slot.idx];
                slot_next[slot.idx] = free_top;
                free_top = slot;
                slots_taken--;
                r.status = ST_DONE;
                r.data = slot_word[slot.idx];
            end
        end
        return r;
    endfunction

    // predict on each accepted word, check each delivered word
    always @(posedge clk)
    begin : word_monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = apply_queue_op(s_tuser[0], s_tuser[QID_W:1], s_tdata);
                if (tag_typed)
                begin
                    want.status = tag_status;
                    want.data = tag_data;
                end
                due_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = '{status: m_tuser, data: m_tdata};
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, got status %0d data %h",
                             $time, got.status, got.data);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.data !== want.data)
                    begin
                        fail_count++;
                        $display("%0t: data mismatch, expected %h, got %h",
                                 $time, want.data, got.data);
                    end
                end
            end
        end
    end

    // receiver ready, with random idling and a long hold on request
    always @(posedge clk)
    begin
        if (rcv_hold_left > 0)
        begin
            m_tready <= 1'b0;
            rcv_hold_left--;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // end the run when nothing moves for too long
    initial
    begin : stall_watch
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall = 0;
            else
                stall++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // offer one word and wait until it is taken
    task automatic send_word(input logic kind, input logic [QID_W-1:0] qid,
                             input logic [WORD_W-1:0] value, input logic typed,
                             input logic [STATUS_W-1:0] st, input logic [WORD_W-1:0] dat);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= {qid, kind};
        tag_typed <= typed;
        tag_status <= st;
        tag_data <= dat;
        do @(posedge clk); while (!s_tready);
    endtask

    // a queue that holds something, when there is one
    function automatic logic [QID_W-1:0] pick_busy_queue();
        int start;
        start = $urandom_range(NUM_QUEUES - 1);
        for (int k = 0; k < NUM_QUEUES; k++)
            if (!pq_head[(start + k) % NUM_QUEUES].nil)
                return QID_W'((start + k) % NUM_QUEUES);
        return QID_W'(start);
    endfunction

    task automatic send_enq();
        send_word(KIND_ENQ, QID_W'($urandom_range(NUM_QUEUES - 1)), $urandom, 1'b0, ST_DONE, '0);
    endtask

    task automatic send_deq(input int busy_pct);
        logic [QID_W-1:0] qid;
        if ($urandom_range(99) < busy_pct)
            qid = pick_busy_queue();
        else
            qid = QID_W'($urandom_range(NUM_QUEUES - 1));
        send_word(KIND_DEQ, qid, $urandom, 1'b0, ST_DONE, '0);
    endtask

    task automatic run_mix(input int count, input int enq_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < enq_pct)
                send_enq();
            else
                send_deq(70);
        end
    endtask

    // push until the store is full, then knock on it a few more times
    task automatic fill_store();
        while (slots_taken < NUM_SLOTS)
        begin
            if ($urandom_range(99) < 90)
                send_enq();
            else
                send_deq(80);
        end
        repeat (6) send_enq();
    endtask

    // pull until every queue is empty, then hit empty queues
    task automatic drain_store();
        while (slots_taken > 0)
        begin
            if ($urandom_range(99) < 85)
                send_deq(90);
            else
                send_enq();
        end
        repeat (8) send_deq(0);
    endtask

    // stop offering until every word in flight has come back
    task automatic wait_results_clear();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
    endtask

    // main sequence
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        tag_typed = 1'b0;
        tag_status = '0;
        tag_data = '0;
        rst_n = 1'b0;
        clear_queue_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender mostly busy, receiver mostly idle
        snd_idle_pct = 15;
        rcv_idle_pct = 74;
        foreach (dir_steps[i])
            send_word(dir_steps[i].kind, dir_steps[i].qid, dir_steps[i].value,
                      dir_steps[i].typed, dir_steps[i].status, dir_steps[i].data);
        run_mix(200, 55);
        fill_store();
        wait_results_clear();

        // sender mostly idle, receiver mostly busy, long receiver hold first
        snd_idle_pct = 74;
        rcv_idle_pct = 15;
        rcv_hold_left = RCV_HOLD_CYCLES;
        run_mix(40, 70);
        drain_store();
        run_mix(200, 50);
        wait_results_clear();

        // no idling on either side
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_mix(350, 55);

        wait_results_clear();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
